/* design/tfsi_pkg.sv */
// tfsi_pkg: shared types, constants and helper functions of the
// thomas-fermi shooting integrator; no dependencies
package tfsi_pkg;

   localparam int DATA_W      = 32;               // potential, slope, radius
   localparam int DX_W        = DATA_W + 1;       // signed radius step
   localparam int MAG_W       = 41;               // capped product magnitude, up to 2^40
   localparam int SUM_W       = MAG_W + 2;        // signed sum before saturation
   localparam int MUL_B_W     = 34;               // second multiplier operand
   localparam int MUL_DIGIT_W = 17;               // bits of that operand taken per step
   localparam int MUL_STEPS   = MUL_B_W / MUL_DIGIT_W;
   localparam int MUL_CNT_W   = 2;

   // integration phase of the current run
   typedef enum logic [1:0] {
      PHASE_NONE  = 2'd0,
      PHASE_FIRST = 2'd1,
      PHASE_LATER = 2'd2
   } phase_type;

   // command to the divide / square root unit
   typedef struct packed {
      logic go;
      logic sqrt_mode;
   } ds_ctl_type;

   // status from either iterative unit
   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   // bits of the square root result
   function automatic int root_w(input int frac);
      return 16 + frac;
   endfunction

   // bits of the first multiplier operand
   function automatic int mul_a_w(input int frac);
      return (root_w(frac) > MAG_W) ? root_w(frac) : MAG_W;
   endfunction

   // base plus or minus a magnitude, saturated to the signed 32-bit range
   function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] base,
                                                 input logic [MAG_W-1:0]  mag,
                                                 input logic              neg);
      logic [SUM_W-1:0] base_ext;
      logic [SUM_W-1:0] mag_ext;
      logic [SUM_W-1:0] sum;
      logic             all_one;
      logic             all_zero;
      base_ext = {{(SUM_W-DATA_W){base[DATA_W-1]}}, base};
      mag_ext  = {2'b00, mag};
      sum      = neg ? (base_ext - mag_ext) : (base_ext + mag_ext);
      all_one  = &sum[SUM_W-1:DATA_W-1];
      all_zero = ~|sum[SUM_W-1:DATA_W-1];
      if (all_one || all_zero) begin
         return sum[DATA_W-1:0];
      end else if (sum[SUM_W-1]) begin
         return {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         return {1'b0, {(DATA_W-1){1'b1}}};
      end
   endfunction

endpackage

/* design/tfsi_divsqrt.sv */
// tfsi_divsqrt: restoring divider and square root sharing one
// compare-subtract unit, one result bit per cycle; uses tfsi_pkg
module tfsi_divsqrt #(
   parameter int FRACTION_BITS = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tfsi_pkg::ds_ctl_type                ctl,
   input  logic [30:0]                         num_i,    // positive potential
   input  logic [31:0]                         den_i,    // previous radius, non-zero
   output tfsi_pkg::unit_stat_type             stat,
   output logic [tfsi_pkg::root_w(FRACTION_BITS)-1:0] root_o // floor(sqrt(quot << F))
);
   import tfsi_pkg::*;

   localparam int QW    = 31 + FRACTION_BITS;
   localparam int SW    = root_w(FRACTION_BITS);
   localparam int RW    = 2 * SW;
   localparam int CW    = (SW + 3 > 33) ? SW + 3 : 33;
   localparam int CNT_W = $clog2(QW + 1);

   logic [RW-1:0]    src_ff,  src_in;
   logic [QW-1:0]    acc_ff,  acc_in;
   logic [CW-1:0]    rem_ff,  rem_in;
   logic [31:0]      den_ff,  den_in;
   logic [CNT_W-1:0] cnt_ff,  cnt_in;
   logic             mode_ff, mode_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [CW-1:0] op_a;
   logic [CW-1:0] op_b;
   logic [CW-1:0] diff;
   logic          borrow;

   // operands of the shared subtractor
   always_comb begin
      if (mode_ff) begin
         op_a = {rem_ff[CW-3:0], src_ff[RW-1:RW-2]};
         op_b = CW'({acc_ff[SW-1:0], 2'b01});
      end else begin
         op_a = {rem_ff[CW-2:0], src_ff[RW-1]};
         op_b = CW'(den_ff);
      end
   end

   // shared compare-subtract
   assign {borrow, diff} = {1'b0, op_a} - {1'b0, op_b};

   // load and iterate
   always_comb begin
      src_in  = src_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      mode_in = mode_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.go) begin
         rem_in  = '0;
         acc_in  = '0;
         busy_in = 1'b1;
         mode_in = ctl.sqrt_mode;
         if (ctl.sqrt_mode) begin
            src_in = {1'b0, acc_ff, {FRACTION_BITS{1'b0}}};
            cnt_in = CNT_W'(SW);
         end else begin
            src_in = {num_i, {(RW-31){1'b0}}};
            den_in = den_i;
            cnt_in = CNT_W'(QW);
         end
      end else if (busy_ff) begin
         rem_in = borrow ? op_a : diff;
         acc_in = {acc_ff[QW-2:0], ~borrow};
         src_in = mode_ff ? (src_ff << 2) : (src_ff << 1);
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         mode_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         mode_ff <= mode_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      src_ff <= src_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign root_o    = acc_ff[SW-1:0];

endmodule

/* design/tfsi_mul.sv */
// tfsi_mul: digit-serial magnitude multiplier, product shifted right by
// the fraction bits and capped at 2^40; uses tfsi_pkg
module tfsi_mul #(
   parameter int FRACTION_BITS = 24
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        go,
   input  logic [tfsi_pkg::mul_a_w(FRACTION_BITS)-1:0] a_i,
   input  logic [tfsi_pkg::MUL_B_W-1:0]                b_i,
   output tfsi_pkg::unit_stat_type                     stat,
   output logic [tfsi_pkg::MAG_W-1:0]                  prod_o
);
   import tfsi_pkg::*;

   localparam int AW = mul_a_w(FRACTION_BITS);
   localparam int PW = AW + MUL_B_W;

   logic [AW-1:0]        a_ff,    a_in;
   logic [MUL_B_W-1:0]   b_ff,    b_in;
   logic [PW-1:0]        acc_ff,  acc_in;
   logic [MUL_CNT_W-1:0] cnt_ff,  cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [MUL_DIGIT_W-1:0]    digit;
   logic [AW+MUL_DIGIT_W-1:0] part;
   logic [PW-1:0]             shifted;
   logic [PW-1:0]             cap;

   // one partial product per cycle, top digit first
   assign digit = b_ff[MUL_B_W-1 -: MUL_DIGIT_W];
   assign part  = a_ff * digit;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (go) begin
         a_in    = a_i;
         b_in    = b_i;
         acc_in  = '0;
         cnt_in  = MUL_CNT_W'(MUL_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = (acc_ff << MUL_DIGIT_W) + PW'(part);
         b_in   = b_ff << MUL_DIGIT_W;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == MUL_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   // truncate the fraction and cap the magnitude
   assign shifted = acc_ff >> FRACTION_BITS;
   assign cap     = PW'(1) << (MAG_W - 1);
   assign prod_o  = (shifted > cap) ? cap[MAG_W-1:0] : shifted[MAG_W-1:0];

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

/* design/thomas_fermi_shooting_integrator_unit.sv */
// thomas_fermi_shooting_integrator_unit: top level with sequencer, run state
// and stream ports; uses tfsi_pkg, tfsi_divsqrt and tfsi_mul
//
// Integrates the Thomas-Fermi equation outward by explicit Euler steps in
// signed fixed point with FRACTION_BITS fraction bits, one grid radius per
// input beat and one result beat per input beat. The block works on one
// point at a time and drops req_tready until that point is finished; a
// finished result waits in an output register, so the next point can be
// taken while the result is still unread. A later point with positive
// potential passes through the bit-serial divider and square root on the
// shared compare-subtract unit, then three products on the two-step
// multiplier. A point that finishes while the previous result is still
// unread waits until that result is taken. The initial slope is written
// through the csr port, which is always ready.
module thomas_fermi_shooting_integrator_unit #(
   parameter int FRACTION_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data,    // initial_slope
   // grid points
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] radius
   input  logic        req_tuser,   // [0] start_of_run
   input  logic        req_tlast,   // end_of_run
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] potential, [63:32] slope_now
   output logic        rsp_tuser,   // [0] fault
   output logic        rsp_tlast    // edge_value
);
   import tfsi_pkg::*;

   localparam int SW = root_w(FRACTION_BITS);
   localparam int AW = mul_a_w(FRACTION_BITS);

   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_DECIDE    = 9'b000000010,
      ST_DIV       = 9'b000000100,
      ST_SQRT      = 9'b000001000,
      ST_MUL_DD    = 9'b000010000,
      ST_MUL_SLOPE = 9'b000100000,
      ST_POT_GO    = 9'b001000000,
      ST_MUL_POT   = 9'b010000000,
      ST_FINISH    = 9'b100000000
   } state_type;

   state_type         state_ff,  state_in;
   logic [31:0]       init_ff,   init_in;
   logic [31:0]       pot_ff,    pot_in;
   logic [31:0]       slope_ff,  slope_in;
   logic [31:0]       prev_ff,   prev_in;
   phase_type         phase_ff,  phase_in;
   logic [31:0]       radius_ff, radius_in;
   logic              start_ff,  start_in;
   logic              last_ff,   last_in;
   logic [DX_W-1:0]   dx_ff,     dx_in;
   logic              fault_ff,  fault_in;
   logic              rvalid_ff, rvalid_in;
   logic [63:0]       rdata_ff,  rdata_in;
   logic              rfault_ff, rfault_in;
   logic              rlast_ff,  rlast_in;

   ds_ctl_type        ds_ctl;
   unit_stat_type     ds_stat;
   logic [SW-1:0]     ds_root;
   logic              mul_go;
   logic [AW-1:0]     mul_a;
   logic [MUL_B_W-1:0] mul_b;
   unit_stat_type     mul_stat;
   logic [MAG_W-1:0]  mul_prod;

   logic              req_fire;
   logic              rsp_fire;
   logic              v_pos;
   logic [DX_W-1:0]   dx_mag;
   logic [31:0]       slope_mag;

   assign req_fire  = req_tvalid && req_tready;
   assign rsp_fire  = rsp_tvalid && rsp_tready;
   assign v_pos     = !pot_ff[31] && (pot_ff != '0);
   assign dx_mag    = dx_ff[DX_W-1] ? (~dx_ff + 1'b1) : dx_ff;
   assign slope_mag = slope_ff[31] ? (~slope_ff + 1'b1) : slope_ff;

   // shared units
   tfsi_divsqrt #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_divsqrt (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ds_ctl),
      .num_i  (pot_ff[30:0]),
      .den_i  (prev_ff),
      .stat   (ds_stat),
      .root_o (ds_root)
   );

   tfsi_mul #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_mul (
      .clock  (clock),
      .reset  (reset),
      .go     (mul_go),
      .a_i    (mul_a),
      .b_i    (mul_b),
      .stat   (mul_stat),
      .prod_o (mul_prod)
   );

   // unit commands and multiplier operands
   always_comb begin
      ds_ctl.go        = 1'b0;
      ds_ctl.sqrt_mode = 1'b0;
      mul_go           = 1'b0;
      mul_a            = AW'(slope_mag);
      mul_b            = MUL_B_W'(dx_mag);
      case (state_ff)
         ST_DECIDE: begin
            ds_ctl.go = !(start_ff || phase_ff == PHASE_NONE) &&
                        phase_ff == PHASE_LATER && v_pos && prev_ff != '0;
         end
         ST_DIV: begin
            ds_ctl.go        = ds_stat.done;
            ds_ctl.sqrt_mode = 1'b1;
         end
         ST_SQRT: begin
            mul_go = ds_stat.done;
            mul_a  = AW'(ds_root);
            mul_b  = MUL_B_W'(pot_ff);
         end
         ST_MUL_DD: begin
            mul_go = mul_stat.done;
            mul_a  = AW'(mul_prod);
         end
         ST_POT_GO: begin
            mul_go = 1'b1;
         end
         default: begin
            mul_go = 1'b0;
         end
      endcase
   end

   // sequencer and run state
   always_comb begin
      state_in  = state_ff;
      init_in   = init_ff;
      pot_in    = pot_ff;
      slope_in  = slope_ff;
      prev_in   = prev_ff;
      phase_in  = phase_ff;
      radius_in = radius_ff;
      start_in  = start_ff;
      last_in   = last_ff;
      dx_in     = dx_ff;
      fault_in  = fault_ff;
      rvalid_in = rvalid_ff && !rsp_fire;
      rdata_in  = rdata_ff;
      rfault_in = rfault_ff;
      rlast_in  = rlast_ff;

      if (csr_valid && csr_ready) begin
         init_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               radius_in = req_tdata;
               start_in  = req_tuser;
               last_in   = req_tlast;
               state_in  = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            fault_in = 1'b0;
            if (start_ff || phase_ff == PHASE_NONE) begin
               // restart of a run
               pot_in   = 32'(1) << FRACTION_BITS;
               slope_in = init_ff;
               prev_in  = radius_ff;
               phase_in = last_ff ? PHASE_NONE : PHASE_FIRST;
               state_in = ST_FINISH;
            end else begin
               dx_in = {1'b0, radius_ff} - {1'b0, prev_ff};
               if (phase_ff == PHASE_LATER && v_pos && prev_ff != '0) begin
                  state_in = ST_DIV;
               end else begin
                  if (phase_ff == PHASE_LATER && v_pos) begin
                     fault_in = 1'b1;
                  end
                  if (phase_ff == PHASE_LATER && !v_pos) begin
                     slope_in = '0;
                  end
                  state_in = ST_POT_GO;
               end
            end
         end
         ST_DIV: begin
            if (ds_stat.done) begin
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (ds_stat.done) begin
               state_in = ST_MUL_DD;
            end
         end
         ST_MUL_DD: begin
            if (mul_stat.done) begin
               state_in = ST_MUL_SLOPE;
            end
         end
         ST_MUL_SLOPE: begin
            // slope grows by v*sqrt(v/x)*dx
            if (mul_stat.done) begin
               slope_in = sat_add(slope_ff, mul_prod, dx_ff[DX_W-1]);
               state_in = ST_POT_GO;
            end
         end
         ST_POT_GO: begin
            state_in = ST_MUL_POT;
         end
         ST_MUL_POT: begin
            // potential grows by slope*dx
            if (mul_stat.done) begin
               pot_in   = sat_add(pot_ff, mul_prod, slope_ff[31] ^ dx_ff[DX_W-1]);
               prev_in  = radius_ff;
               phase_in = last_ff ? PHASE_NONE : PHASE_LATER;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rvalid_ff || rsp_tready) begin
               rvalid_in = 1'b1;
               rdata_in  = {slope_ff, pot_ff};
               rfault_in = fault_ff;
               rlast_in  = last_ff;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         init_ff   <= '0;
         pot_ff    <= '0;
         slope_ff  <= '0;
         prev_ff   <= '0;
         phase_ff  <= PHASE_NONE;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         init_ff   <= init_in;
         pot_ff    <= pot_in;
         slope_ff  <= slope_in;
         prev_ff   <= prev_in;
         phase_ff  <= phase_in;
         rvalid_ff <= rvalid_in;
      end
   end

   // item and result payload
   always_ff @(posedge clock) begin
      radius_ff <= radius_in;
      start_ff  <= start_in;
      last_ff   <= last_in;
      dx_ff     <= dx_in;
      fault_ff  <= fault_in;
      rdata_ff  <= rdata_in;
      rfault_ff <= rfault_in;
      rlast_ff  <= rlast_in;
   end

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = rdata_ff;
   assign rsp_tuser  = rfault_ff;
   assign rsp_tlast  = rlast_ff;

   // no beat is taken while either unit is still iterating
   a_idle_units: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (!ds_stat.busy && !mul_stat.busy))
      else $error("input ready while an arithmetic unit is busy");

   // the two units never iterate at the same time
   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      !(ds_stat.busy && mul_stat.busy))
      else $error("divider and multiplier busy together");

   // a product only completes while the sequencer waits for one
   a_mul_done: assert property (@(posedge clock) disable iff (reset)
      mul_stat.done |-> (state_ff == ST_MUL_DD || state_ff == ST_MUL_SLOPE ||
                         state_ff == ST_MUL_POT))
      else $error("multiplier finished outside a product state");

   // an accepted beat is decided on in the next cycle
   a_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_DECIDE))
      else $error("accepted beat not followed by decision");

endmodule
